// File: rtl/core/hrmc_pkg.sv
package hrmc_pkg;

  localparam int DEPTH   = 64;
  localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int ID_W    = 10;
  localparam int TURN_W  = 16;
  localparam int ENT_W   = ID_W + TURN_W;
  localparam int CNT_W   = 6;
  localparam int IN_DW   = 32;
  localparam int OUT_DW  = 8;

  typedef logic [PTR_W-1:0]  ptr_t;
  typedef logic [ID_W-1:0]   id_t;
  typedef logic [TURN_W-1:0] turn_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  localparam cnt_t CNT_MAX = '1;
  localparam ptr_t PTR_LAST = PTR_W'(DEPTH - 1);

  typedef enum logic {
    CMD_ADD   = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_RESP
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic add;    // write record at write pointer
    logic start;  // latch query key, arm walk
    logic walk;   // step walk one slot
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic done;
  } dp_sts_t;

  function automatic ptr_t ptr_prev(ptr_t p);
    ptr_t r;
    r = (p == '0) ? PTR_LAST : p - 1'b1;
    return r;
  endfunction

  function automatic ptr_t ptr_next(ptr_t p);
    ptr_t r;
    r = (p == PTR_LAST) ? '0 : p + 1'b1;
    return r;
  endfunction

endpackage

// File: rtl/core/hrmc_ram.sv
module hrmc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/core/hrmc_ctrl.sv
module hrmc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic              in_cmd,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  output hrmc_pkg::dp_cmd_t dp_cmd,
  input  hrmc_pkg::dp_sts_t dp_sts
);

  hrmc_pkg::state_t state_r, state_nxt;
  logic             in_acc;

  assign in_acc = in_tvalid && (state_r == hrmc_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= hrmc_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      hrmc_pkg::ST_IDLE: begin
        if (in_acc && (hrmc_pkg::cmd_t'(in_cmd) == hrmc_pkg::CMD_QUERY)) begin
          state_nxt = hrmc_pkg::ST_WALK;
        end
      end
      hrmc_pkg::ST_WALK: begin
        if (dp_sts.done) begin
          state_nxt = hrmc_pkg::ST_RESP;
        end
      end
      hrmc_pkg::ST_RESP: begin
        if (out_tready) begin
          state_nxt = hrmc_pkg::ST_IDLE;
        end
      end
      default: state_nxt = hrmc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready    = 1'b0;
    out_tvalid   = 1'b0;
    dp_cmd       = '0;
    case (state_r)
      hrmc_pkg::ST_IDLE: begin
        in_tready    = 1'b1;
        dp_cmd.add   = in_acc && (hrmc_pkg::cmd_t'(in_cmd) == hrmc_pkg::CMD_ADD);
        dp_cmd.start = in_acc && (hrmc_pkg::cmd_t'(in_cmd) == hrmc_pkg::CMD_QUERY);
      end
      hrmc_pkg::ST_WALK: begin
        dp_cmd.walk = 1'b1;
      end
      hrmc_pkg::ST_RESP: begin
        out_tvalid = 1'b1;
      end
      default: ;
    endcase
  end

endmodule

// File: rtl/core/hrmc_dp.sv
module hrmc_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  hrmc_pkg::dp_cmd_t dp_cmd,
  output hrmc_pkg::dp_sts_t dp_sts,
  input  hrmc_pkg::id_t     in_id,
  input  hrmc_pkg::turn_t   in_turn,
  output logic              found,
  output hrmc_pkg::cnt_t    match_count
);

  hrmc_pkg::ptr_t            wp_r;
  hrmc_pkg::ptr_t            p_r;
  logic [hrmc_pkg::DEPTH-1:0] vld_r;
  logic                      vld_q_r;
  logic                      pend_r;
  logic                      chk_r;
  hrmc_pkg::id_t             key_id_r;
  hrmc_pkg::turn_t           key_turn_r;
  hrmc_pkg::cnt_t            count_r;
  logic                      found_r;

  logic [hrmc_pkg::ENT_W-1:0] rd_data;
  hrmc_pkg::id_t              rd_id;
  hrmc_pkg::turn_t            rd_turn;
  logic                       is_null;
  logic                       match;

  hrmc_ram #(
    .WIDTH (hrmc_pkg::ENT_W),
    .DEPTH (hrmc_pkg::DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (dp_cmd.add),
    .waddr (wp_r),
    .wdata ({in_id, in_turn}),
    .raddr (p_r),
    .rdata (rd_data)
  );

  assign rd_id   = rd_data[hrmc_pkg::ENT_W-1:hrmc_pkg::TURN_W];
  assign rd_turn = rd_data[hrmc_pkg::TURN_W-1:0];

  // never-written slots read as null through the valid bit
  assign is_null = !vld_q_r || (rd_id == '0);
  assign match   = pend_r && chk_r && !is_null &&
                   (rd_id == key_id_r) && (rd_turn == key_turn_r);
  // chk_r low: the read slot was the write pointer, walk has wrapped
  assign dp_sts.done = pend_r && (!chk_r || is_null);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= '0;
      vld_r  <= '0;
      pend_r <= 1'b0;
    end else begin
      if (dp_cmd.add) begin
        vld_r[wp_r] <= 1'b1;
        wp_r        <= hrmc_pkg::ptr_next(wp_r);
      end
      if (dp_cmd.start) begin
        pend_r <= 1'b0;
      end else if (dp_cmd.walk) begin
        pend_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    vld_q_r <= vld_r[p_r];
    if (dp_cmd.start) begin
      key_id_r   <= in_id;
      key_turn_r <= in_turn;
      p_r        <= hrmc_pkg::ptr_prev(wp_r);
      chk_r      <= 1'b1;
      count_r    <= '0;
      found_r    <= 1'b0;
    end else if (dp_cmd.walk) begin
      p_r   <= hrmc_pkg::ptr_prev(p_r);
      chk_r <= (p_r != wp_r);
      if (match) begin
        found_r <= 1'b1;
        if (count_r != hrmc_pkg::CNT_MAX) begin
          count_r <= count_r + 1'b1;
        end
      end
    end
  end

  assign found       = found_r;
  assign match_count = count_r;

endmodule

// File: rtl/core/history_ring_match_counter.sv
// Add: accepted with no result; next item accepted the cycle after.
// Query: one ring slot read per cycle from the record RAM (registered read),
//   at most DEPTH-1 slots walked; one item at a time while a query is in flight.
// Reset: synchronous, active low; write pointer zero, all slot valid bits
//   cleared so every slot reads as null at once (no clearing pass).
module history_ring_match_counter (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [hrmc_pkg::IN_DW-1:0]  in_tdata,   // [9:0] move_id, [25:10] turn, rest zero
  input  logic                        in_tuser,   // [0] cmd
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [hrmc_pkg::OUT_DW-1:0] out_tdata   // [0] found, [6:1] match_count, [7] zero
);

  hrmc_pkg::dp_cmd_t dp_cmd;
  hrmc_pkg::dp_sts_t dp_sts;
  logic              found;
  hrmc_pkg::cnt_t    match_count;

  hrmc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_cmd     (in_tuser),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .dp_cmd     (dp_cmd),
    .dp_sts     (dp_sts)
  );

  hrmc_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .dp_cmd      (dp_cmd),
    .dp_sts      (dp_sts),
    .in_id       (in_tdata[hrmc_pkg::ID_W-1:0]),
    .in_turn     (in_tdata[hrmc_pkg::ENT_W-1:hrmc_pkg::ID_W]),
    .found       (found),
    .match_count (match_count)
  );

  assign out_tdata = {{(hrmc_pkg::OUT_DW - hrmc_pkg::CNT_W - 1){1'b0}}, match_count, found};

endmodule
